[rtl/core/awac_pkg.sv]
// shared constants and types for the alpha weighted average color core
`timescale 1ns / 1ps

package awac_pkg;

   localparam int unsigned MAX_CANVAS = 256;

   localparam int CHAN_W     = 8;
   localparam int SCALED_W   = 16;
   localparam int SUM_W      = 33;
   localparam int ALPHA_W    = 24;
   localparam int COUNT_W    = 17;
   localparam int SIZE_W     = 9;
   localparam int AREA_W     = 2 * SIZE_W;
   localparam int SIZE_CMP_W = 11;
   localparam int COLOR_W    = 3 * CHAN_W;
   localparam int PIXEL_W    = 4 * CHAN_W;
   localparam int DVS_W      = ALPHA_W + CHAN_W;
   localparam int STEP_W     = 4;

   localparam logic [CHAN_W-1:0] ALPHA_SKIP   = 8'd24;
   localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
   localparam logic [SIZE_W-1:0] CANVAS_RESET = 9'd64;
   localparam logic [STEP_W-1:0] STEP_LAST    = 4'd8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_CANVAS = 1'b0;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

endpackage

[rtl/core/alpha_weighted_average_color_core.sv]
// alpha weighted average color over one square canvas of bgra pixels
// a pixel without tlast is taken while idle, one pixel per cycle
// after a tlast pixel the block runs S_CHECK, S_DIV (not on a bad or none status)
// and S_DONE; S_DIV runs 9 shared compare/subtract steps for each of 3 channels
// req_tready stays low from the tlast pixel until its result is in the output register
// synchronous active-high reset: canvas_size 64, all sums and the pixel counter zero
`timescale 1ns / 1ps

module alpha_weighted_average_color_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [awac_pkg::PIXEL_W-1:0]     req_tdata,   // blue, green, red, alpha
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [awac_pkg::COLOR_W-1:0]     rsp_tdata,   // color (blue, green, red)
   output logic [1:0]                       rsp_tuser,   // status
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [awac_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [awac_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [awac_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import awac_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   function automatic logic [SCALED_W-1:0] scale_chan(input logic [CHAN_W-1:0] c);
      scale_chan = {c, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, c};
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                input logic [SCALED_W-1:0] add);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + (SUM_W+1)'(add);
      sat_sum = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [SIZE_W-1:0]       canvas_size_ff, canvas_size_in;
   logic [SUM_W-1:0]        red_sum_ff, red_sum_in;
   logic [SUM_W-1:0]        green_sum_ff, green_sum_in;
   logic [SUM_W-1:0]        blue_sum_ff, blue_sum_in;
   logic [ALPHA_W-1:0]      alpha_total_ff, alpha_total_in;
   logic [COUNT_W-1:0]      pixel_count_ff, pixel_count_in;
   logic [SUM_W-1:0]        rem_ff, rem_in;
   logic [DVS_W-1:0]        dvs_ff, dvs_in;
   logic [CHAN_W-1:0]       quo_ff, quo_in;
   logic                    sat_ff, sat_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [1:0]              chan_ff, chan_in;
   logic [COLOR_W-1:0]      color_ff, color_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]      rsp_color_ff, rsp_color_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic [CHAN_W-1:0]       pix_blue, pix_green, pix_red, pix_alpha;
   logic                    req_fire;
   logic                    csr_write;
   logic [AREA_W-1:0]       canvas_area;
   logic                    size_bad;
   logic                    count_bad;
   logic                    ge;
   logic [SUM_W-1:0]        diff;
   logic [CHAN_W-1:0]       quo_next;
   logic [CHAN_W-1:0]       chan_byte;
   logic                    rsp_load;
   logic [SUM_W-1:0]        next_sum;

   assign pix_blue  = req_tdata[CHAN_W-1:0];
   assign pix_green = req_tdata[2*CHAN_W-1:CHAN_W];
   assign pix_red   = req_tdata[3*CHAN_W-1:2*CHAN_W];
   assign pix_alpha = req_tdata[4*CHAN_W-1:3*CHAN_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CANVAS) ?
                       {{(CSR_DATA_W-SIZE_W){1'b0}}, canvas_size_ff} : '0;

   assign canvas_area = AREA_W'(canvas_size_ff) * AREA_W'(canvas_size_ff);
   assign size_bad    = (canvas_size_ff == '0) ||
                        (SIZE_CMP_W'(canvas_size_ff) > SIZE_CMP_W'(MAX_CANVAS));
   assign count_bad   = ({{(AREA_W-COUNT_W){1'b0}}, pixel_count_ff} != canvas_area);

   // shared compare/subtract against the shifted weight
   assign ge        = (rem_ff >= {{(SUM_W-DVS_W){1'b0}}, dvs_ff});
   assign diff      = rem_ff - {{(SUM_W-DVS_W){1'b0}}, dvs_ff};
   assign quo_next  = {quo_ff[CHAN_W-2:0], ge};
   assign chan_byte = sat_ff ? CHAN_MAX : quo_next;

   assign rsp_load  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (chan_ff)
         CH_RED:   next_sum = green_sum_ff;
         CH_GREEN: next_sum = blue_sum_ff;
         default:  next_sum = blue_sum_ff;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      canvas_size_in = canvas_size_ff;
      red_sum_in     = red_sum_ff;
      green_sum_in   = green_sum_ff;
      blue_sum_in    = blue_sum_ff;
      alpha_total_in = alpha_total_ff;
      pixel_count_in = pixel_count_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      quo_in         = quo_ff;
      sat_in         = sat_ff;
      step_in        = step_ff;
      chan_in        = chan_ff;
      color_in       = color_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_color_in   = rsp_color_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_write && (csr_paddr[2] == CSR_IDX_CANVAS)) begin
         canvas_size_in = csr_pwdata[SIZE_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (pixel_count_ff != {COUNT_W{1'b1}}) begin
                  pixel_count_in = pixel_count_ff + 1'b1;
               end
               if (pix_alpha > ALPHA_SKIP) begin
                  blue_sum_in  = sat_sum(blue_sum_ff, scale_chan(pix_blue));
                  green_sum_in = sat_sum(green_sum_ff, scale_chan(pix_green));
                  red_sum_in   = sat_sum(red_sum_ff, scale_chan(pix_red));
                  if ((ALPHA_W+1)'(alpha_total_ff) + (ALPHA_W+1)'(pix_alpha) >
                      (ALPHA_W+1)'({ALPHA_W{1'b1}})) begin
                     alpha_total_in = {ALPHA_W{1'b1}};
                  end else begin
                     alpha_total_in = alpha_total_ff + ALPHA_W'(pix_alpha);
                  end
               end
               if (req_tlast) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            color_in = '0;
            rem_in   = red_sum_ff;
            dvs_in   = {alpha_total_ff, {CHAN_W{1'b0}}};
            quo_in   = '0;
            sat_in   = 1'b0;
            step_in  = '0;
            chan_in  = CH_RED;
            if (size_bad || count_bad) begin
               status_in = ST_BAD;
               state_in  = S_DONE;
            end else if (alpha_total_ff == '0) begin
               status_in = ST_NONE;
               state_in  = S_DONE;
            end else begin
               status_in = ST_OK;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            dvs_in = dvs_ff >> 1;
            if (step_ff == '0) begin
               // first step only checks for a quotient of 256 or more
               sat_in = ge;
            end else begin
               quo_in = quo_next;
               if (ge) begin
                  rem_in = diff;
               end
            end
            if (step_ff == STEP_LAST) begin
               color_in = {color_ff[COLOR_W-CHAN_W-1:0], chan_byte};
               if (chan_ff == CH_BLUE) begin
                  state_in = S_DONE;
               end else begin
                  chan_in = chan_ff + 1'b1;
                  rem_in  = next_sum;
                  dvs_in  = {alpha_total_ff, {CHAN_W{1'b0}}};
                  quo_in  = '0;
                  sat_in  = 1'b0;
                  step_in = '0;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_color_in   = color_ff;
               rsp_status_in  = status_ff;
               red_sum_in     = '0;
               green_sum_in   = '0;
               blue_sum_in    = '0;
               alpha_total_in = '0;
               pixel_count_in = '0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         canvas_size_ff <= CANVAS_RESET;
         red_sum_ff     <= '0;
         green_sum_ff   <= '0;
         blue_sum_ff    <= '0;
         alpha_total_ff <= '0;
         pixel_count_ff <= '0;
         step_ff        <= '0;
         chan_ff        <= CH_RED;
         rsp_valid_ff   <= 1'b0;
         rsp_color_ff   <= '0;
         rsp_status_ff  <= ST_OK;
      end else begin
         state_ff       <= state_in;
         canvas_size_ff <= canvas_size_in;
         red_sum_ff     <= red_sum_in;
         green_sum_ff   <= green_sum_in;
         blue_sum_ff    <= blue_sum_in;
         alpha_total_ff <= alpha_total_in;
         pixel_count_ff <= pixel_count_in;
         step_ff        <= step_in;
         chan_ff        <= chan_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_color_ff   <= rsp_color_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      quo_ff        <= quo_in;
      sat_ff        <= sat_in;
      color_ff      <= color_in;
      status_ff     <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_error_color_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0)
      else $error("error status with nonzero color");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_load |=>
         (pixel_count_ff == '0) && (alpha_total_ff == '0) && (red_sum_ff == '0))
      else $error("accumulators not cleared after result");

   a_no_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (alpha_total_ff != '0))
      else $error("divide by zero weight");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (step_ff <= STEP_LAST) && (chan_ff != 2'd3))
      else $error("divider step out of range");
`endif

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the alpha weighted average color core
`timescale 1ns / 1ps

module tb_top;
   import awac_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD = 400;
   localparam int PHASE_ITEMS = 350;
   localparam logic [CSR_ADDR_W-1:0] CANVAS_ADDR = {CSR_IDX_CANVAS, 2'b00};
   localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 1;
   localparam logic [63:0] WEIGHT_LIMIT = (64'd1 << ALPHA_W) - 1;
   localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_W) - 1;

   typedef struct {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] alpha;
      logic              last;
   } pixel_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      status_type         status;
   } avg_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;   // blue, green, red, alpha
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [COLOR_W-1:0]    rsp_tdata;        // color: blue, green, red
   logic [1:0]            rsp_tuser;        // status
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor copy of the block state
   logic [SIZE_W-1:0]  canvas_reg = CANVAS_RESET;
   logic [SUM_W-1:0]   red_acc = '0;
   logic [SUM_W-1:0]   green_acc = '0;
   logic [SUM_W-1:0]   blue_acc = '0;
   logic [ALPHA_W-1:0] weight_acc = '0;
   logic [COUNT_W-1:0] pixel_tally = '0;
   avg_result_type     expected_averages[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_taken = 0;
   int hold_left = 0;

   alpha_weighted_average_color_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** alpha_weighted_average_color_core: FAILED **");
         $finish;
      end
   end

   function automatic logic [63:0] clamp_add(input logic [63:0] acc, input logic [63:0] add,
                                             input logic [63:0] limit);
      logic [63:0] total;
      total = acc + add;
      return (total > limit) ? limit : total;
   endfunction

   function automatic logic [CHAN_W-1:0] channel_mean(input logic [SUM_W-1:0] sum,
                                                      input logic [ALPHA_W-1:0] weight);
      logic [SUM_W-1:0] quotient;
      quotient = sum / weight;
      return (quotient > CHAN_MAX) ? CHAN_MAX : quotient[CHAN_W-1:0];
   endfunction

   // fold one accepted pixel into the running averages, close the canvas on tlast
   function automatic void fold_pixel(input pixel_type p);
      avg_result_type res;
      int unsigned area;
      pixel_tally = COUNT_W'(clamp_add(64'(pixel_tally), 64'd1, COUNT_LIMIT));
      if (p.alpha > ALPHA_SKIP) begin
         blue_acc = SUM_W'(clamp_add(64'(blue_acc), {56'd0, p.blue} * CHAN_MAX, SUM_LIMIT));
         green_acc = SUM_W'(clamp_add(64'(green_acc), {56'd0, p.green} * CHAN_MAX,
                                      SUM_LIMIT));
         red_acc = SUM_W'(clamp_add(64'(red_acc), {56'd0, p.red} * CHAN_MAX, SUM_LIMIT));
         weight_acc = ALPHA_W'(clamp_add(64'(weight_acc), {56'd0, p.alpha}, WEIGHT_LIMIT));
      end
      if (p.last) begin
         area = 32'(canvas_reg) * 32'(canvas_reg);
         res.color = '0;
         if (canvas_reg == 0 || canvas_reg > MAX_CANVAS || 32'(pixel_tally) != area) begin
            res.status = ST_BAD;
         end else if (weight_acc == 0) begin
            res.status = ST_NONE;
         end else begin
            res.status = ST_OK;
            res.color = {channel_mean(red_acc, weight_acc), channel_mean(green_acc, weight_acc),
                         channel_mean(blue_acc, weight_acc)};
         end
         expected_averages.push_back(res);
         red_acc = '0;
         green_acc = '0;
         blue_acc = '0;
         weight_acc = '0;
         pixel_tally = '0;
      end
   endfunction

   function automatic pixel_type make_pixel(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r, input logic [7:0] a,
                                            input logic last);
      pixel_type p;
      p.blue = b;
      p.green = g;
      p.red = r;
      p.alpha = a;
      p.last = last;
      return p;
   endfunction

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return CHAN_MAX;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_type random_pixel(input bit transparent);
      pixel_type p;
      p.blue = random_channel();
      p.green = random_channel();
      p.red = random_channel();
      p.last = 1'b0;
      if (transparent) begin
         p.alpha = CHAN_W'($urandom_range(ALPHA_SKIP));
      end else begin
         case ($urandom_range(5))
            0: p.alpha = CHAN_W'($urandom_range(ALPHA_SKIP));
            1: p.alpha = ALPHA_SKIP + CHAN_W'($urandom_range(1));
            default: p.alpha = CHAN_W'($urandom_range(255));
         endcase
      end
      return p;
   endfunction

   // called right after an edge; returns at the edge where the request is taken
   task automatic send_pixel(input pixel_type p);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {p.alpha, p.red, p.green, p.blue};
      req_tlast <= p.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fold_pixel(p);
   endtask

   task automatic send_canvas(input int pixels, input bit transparent);
      pixel_type p;
      for (int i = 1; i <= pixels; i++) begin
         p = random_pixel(transparent);
         p.last = (i == pixels);
         send_pixel(p);
      end
   endtask

   // drop valid, let every pending result drain and the divider finish
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_averages.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_canvas(input logic [SIZE_W-1:0] side);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CANVAS_ADDR;
      // upper bits carry noise, only the low size bits are kept
      csr_pwdata <= {junk[CSR_DATA_W-1:SIZE_W], side};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      canvas_reg = side;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_requests != holds_taken) begin
         holds_taken = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_averages
      avg_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_averages.size() == 0) begin
            $error("result with no canvas pending: color %06h status %0d", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_averages.pop_front();
            if (rsp_tdata !== want.color) begin
               $error("color mismatch: expected %06h, actual %06h", want.color, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   // relies on the reset value of canvas_size, so it runs first
   task automatic test_reset_canvas();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(negedge clock);
      csr_paddr <= CANVAS_ADDR;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(CANVAS_RESET)) begin
         $error("canvas_size mismatch: expected %0d, actual %0d", CANVAS_RESET, csr_prdata);
         mismatch_count++;
      end
      // short canvas under the reset size
      send_canvas(8, 1'b0);
      settle_block();
   endtask

   task automatic test_directed_cases();
      write_canvas(SIZE_W'(1));
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));
      // just above the alpha threshold, the red channel clamps at full scale
      send_pixel(make_pixel(8'd10, 8'd20, 8'd30, ALPHA_SKIP + 8'd1, 1'b1));
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, ALPHA_SKIP, 1'b1));
      send_pixel(make_pixel(8'hAA, 8'h55, 8'hFF, 8'h00, 1'b1));
      settle_block();
      write_canvas(SIZE_W'(2));
      send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'hFF, 1'b0));
      send_pixel(make_pixel(8'd0, 8'd255, 8'd1, ALPHA_SKIP, 1'b0));
      send_pixel(make_pixel(8'd255, 8'd0, 8'd128, ALPHA_SKIP + 8'd1, 1'b0));
      send_pixel(make_pixel(8'd7, 8'd9, 8'd11, 8'd128, 1'b1));
      // short and long canvases
      send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd200, 1'b0));
      send_pixel(make_pixel(8'd4, 8'd5, 8'd6, 8'd200, 1'b0));
      send_pixel(make_pixel(8'd7, 8'd8, 8'd9, 8'd200, 1'b1));
      send_canvas(5, 1'b0);
      send_canvas(4, 1'b1);
      settle_block();
      write_canvas(SIZE_W'(0));
      send_pixel(make_pixel(8'd90, 8'd80, 8'd70, 8'hFF, 1'b1));
      settle_block();
      write_canvas(SIZE_W'(MAX_CANVAS + 1));
      send_pixel(make_pixel(8'd90, 8'd80, 8'd70, 8'hFF, 1'b1));
      settle_block();
      write_canvas('1);
      send_pixel(make_pixel(8'd90, 8'd80, 8'd70, 8'hFF, 1'b1));
      // size change in the middle of a canvas keeps the partial sums
      settle_block();
      write_canvas(SIZE_W'(3));
      send_pixel(make_pixel(8'd12, 8'd34, 8'd56, 8'd78, 1'b0));
      send_pixel(make_pixel(8'd250, 8'd3, 8'd99, 8'd255, 1'b0));
      send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd10, 1'b0));
      settle_block();
      write_canvas(SIZE_W'(2));
      send_pixel(make_pixel(8'd128, 8'd64, 8'd32, 8'd30, 1'b1));
      settle_block();
   endtask

   // largest canvas size with a short pixel run
   task automatic test_full_canvas();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_canvas(SIZE_W'(MAX_CANVAS));
      send_canvas(int'(MAX_CANVAS), 1'b0);
      settle_block();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_canvas(SIZE_W'(2));
      hold_requests++;
      repeat (12) send_canvas(4, 1'b0);
      settle_block();
   endtask

   task automatic test_random_canvases(input int send_pct, input int recv_pct);
      int sent;
      int side;
      int pixels;
      int roll;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         if (sent == 0 || $urandom_range(3) == 0) begin
            roll = $urandom_range(99);
            if (roll < 80) side = $urandom_range(4, 1);
            else if (roll < 93) side = $urandom_range(8, 5);
            else if (roll < 96) side = $urandom_range(12, 9);
            else if (roll < 98) side = 0;
            else side = $urandom_range(511, MAX_CANVAS + 1);
            settle_block();
            write_canvas(SIZE_W'(side));
         end
         if (canvas_reg == 0 || canvas_reg > MAX_CANVAS) begin
            pixels = $urandom_range(6, 1);
         end else begin
            pixels = int'(canvas_reg) * int'(canvas_reg);
            roll = $urandom_range(15);
            if (roll == 0) pixels = pixels + $urandom_range(3, 1);
            else if (roll == 1 && pixels > 1) pixels = $urandom_range(pixels - 1, 1);
         end
         send_canvas(pixels, $urandom_range(9) == 0);
         sent += pixels;
      end
      settle_block();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_canvas();
      test_directed_cases();
      test_full_canvas();
      test_output_backpressure();
      test_random_canvases(0, 0);
      test_random_canvases(77, 0);
      test_random_canvases(0, 77);
      test_random_canvases(12, 12);
      if (mismatch_count == 0 && expected_averages.size() == 0) begin
         $display("** alpha_weighted_average_color_core: PASSED **");
      end else begin
         $display("** alpha_weighted_average_color_core: FAILED **");
      end
      $finish;
   end

endmodule

[alpha_weighted_average_color_core.f]
rtl/core/awac_pkg.sv
rtl/core/alpha_weighted_average_color_core.sv
tb/sv/tb_top.sv
